@@ design/fns_pkg.sv @@
package fns_pkg;

   localparam int NORM_W    = 16;
   localparam int COORD_W   = 32;
   localparam int RED_BITS  = 30;
   localparam int SUM_W     = 2 * RED_BITS + 2;
   localparam int LEN_W     = RED_BITS + 1;
   localparam int QUOT_W    = 15;
   localparam int FRAC_BITS = 14;

   localparam logic [15:0] SCALE_RESET = 16'd256;
   localparam logic [QUOT_W-1:0] NORM_ONE = 15'd16384;

   localparam int LAT_SCALE = 2;
   localparam int LAT_CROSS = 9;
   localparam int LAT_SQRT  = 31;
   localparam int LAT_DIV   = QUOT_W + 1;
   localparam int LAT_TOTAL = LAT_SCALE + LAT_CROSS + LAT_SQRT + LAT_DIV + 1;

   typedef logic [8:0][COORD_W-1:0] vert_type;
   typedef logic [2:0][NORM_W-1:0]  nrm_type;
   typedef logic [2:0][RED_BITS-1:0] mag_type;

endpackage

@@ design/fns_delay.sv @@
module fns_delay import fns_pkg::*; #(
   parameter int W = 8,
   parameter int D = 2
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] line_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int k = 1; k < D; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   assign dout = line_ff[D-1];

endmodule

@@ design/fns_scale.sv @@
module fns_scale import fns_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] scale,
   input  vert_type    vin,
   output vert_type    vout
);

   logic signed [48:0] prod_ff [9];
   vert_type           sat_ff;
   vert_type           sat_in;

   always_comb begin
      logic signed [40:0] q;
      for (int i = 0; i < 9; i++) begin
         q = 41'(prod_ff[i] >>> 8);
         if (q[40:31] == '0 || q[40:31] == '1) begin
            sat_in[i] = q[31:0];
         end else if (q[40]) begin
            sat_in[i] = 32'h8000_0000;
         end else begin
            sat_in[i] = 32'h7fff_ffff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= $signed(vin[i]) * $signed({1'b0, scale});
         end
         sat_ff <= sat_in;
      end
   end

   assign vout = sat_ff;

endmodule

@@ design/fns_cross.sv @@
module fns_cross import fns_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  vert_type         v,
   output mag_type          m,
   output logic [2:0]       neg,
   output logic [SUM_W-1:0] sum
);

   logic signed [32:0] u_ff [3];
   logic signed [32:0] w_ff [3];
   logic signed [65:0] p_ff [6];
   logic signed [66:0] t_ff [3];
   logic [66:0]        mag_ff [3];
   logic [66:0]        mag2_ff [3];
   logic [66:0]        mag3_ff [3];
   logic [2:0]         neg_ff [6];
   logic [66:0]        or_ff;
   logic [6:0]         sh_ff;
   logic [6:0]         sh_in;
   mag_type            m_ff;
   mag_type            m2_ff;
   mag_type            m3_ff;
   logic [59:0]        sq_ff [3];
   logic [SUM_W-1:0]   sum_ff;

   always_comb begin
      logic [6:0] len;
      len = '0;
      for (int i = 0; i < 67; i++) begin
         if (or_ff[i]) begin
            len = 7'(i + 1);
         end
      end
      sh_in = (len > 7'(RED_BITS)) ? len - 7'(RED_BITS) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i] <= $signed({v[3+i][31], v[3+i]}) - $signed({v[i][31], v[i]});
            w_ff[i] <= $signed({v[6+i][31], v[6+i]}) - $signed({v[i][31], v[i]});
         end
         p_ff[0] <= u_ff[1] * w_ff[2];
         p_ff[1] <= u_ff[2] * w_ff[1];
         p_ff[2] <= u_ff[2] * w_ff[0];
         p_ff[3] <= u_ff[0] * w_ff[2];
         p_ff[4] <= u_ff[0] * w_ff[1];
         p_ff[5] <= u_ff[1] * w_ff[0];
         for (int i = 0; i < 3; i++) begin
            t_ff[i]   <= 67'(p_ff[2*i]) - 67'(p_ff[2*i+1]);
            neg_ff[0][i] <= t_ff[i][66];
            mag_ff[i] <= t_ff[i][66] ? 67'(-t_ff[i]) : 67'(t_ff[i]);
            mag2_ff[i] <= mag_ff[i];
            mag3_ff[i] <= mag2_ff[i];
            m_ff[i]   <= RED_BITS'(mag3_ff[i] >> sh_ff);
            m2_ff[i]  <= m_ff[i];
            m3_ff[i]  <= m2_ff[i];
            sq_ff[i]  <= m_ff[i] * m_ff[i];
         end
         or_ff  <= mag_ff[0] | mag_ff[1] | mag_ff[2];
         sh_ff  <= sh_in;
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         for (int k = 1; k < 6; k++) begin
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign m   = m3_ff;
   assign neg = neg_ff[5];
   assign sum = sum_ff;

endmodule

@@ design/fns_sqrt.sv @@
module fns_sqrt import fns_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [SUM_W-1:0] v,
   output logic [LEN_W-1:0] root
);

   logic [SUM_W-1:0] rem_ff  [LAT_SQRT];
   logic [62:0]      root_ff [LAT_SQRT];

   for (genvar k = 0; k < LAT_SQRT; k++) begin : g_stage
      localparam logic [62:0] BIT = 63'(1) << (2 * (LAT_SQRT - 1 - k));
      logic [SUM_W-1:0] rem_prev;
      logic [62:0]      root_prev;
      logic [62:0]      trial;
      if (k == 0) begin : g_first
         assign rem_prev  = v;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end
      assign trial = root_prev + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (63'(rem_prev) >= trial) begin
               rem_ff[k]  <= SUM_W'(63'(rem_prev) - trial);
               root_ff[k] <= (root_prev >> 1) + BIT;
            end else begin
               rem_ff[k]  <= rem_prev;
               root_ff[k] <= root_prev >> 1;
            end
         end
      end
   end

   assign root = root_ff[LAT_SQRT-1][LEN_W-1:0];

endmodule

@@ design/fns_div.sv @@
module fns_div import fns_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [RED_BITS-1:0] m,
   input  logic [LEN_W-1:0]    len,
   output logic [QUOT_W-1:0]   quot
);

   localparam int NUM_W = RED_BITS + FRAC_BITS + 1;

   logic [NUM_W-1:0]  num_ff;
   logic [LEN_W-1:0]  den_ff [QUOT_W];
   logic [NUM_W-1:0]  rem_ff [QUOT_W];
   logic [QUOT_W-1:0] q_ff   [QUOT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff    <= NUM_W'({m, FRAC_BITS'(0)}) + NUM_W'(len >> 1);
         den_ff[0] <= len;
         for (int k = 1; k < QUOT_W; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      localparam int S = QUOT_W - 1 - k;
      logic [NUM_W-1:0]  rem_prev;
      logic [QUOT_W-1:0] q_prev;
      logic [NUM_W+S:0]  trial;
      if (k == 0) begin : g_first
         assign rem_prev = num_ff;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end
      assign trial = (NUM_W+S+1)'(den_ff[k]) << S;
      always_ff @(posedge clock) begin
         if (en) begin
            if ((NUM_W+S+1)'(rem_prev) >= trial) begin
               rem_ff[k] <= NUM_W'((NUM_W+S+1)'(rem_prev) - trial);
               q_ff[k]   <= q_prev | (QUOT_W'(1) << S);
            end else begin
               rem_ff[k] <= rem_prev;
               q_ff[k]   <= q_prev;
            end
         end
      end
   end

   assign quot = q_ff[QUOT_W-1];

endmodule

@@ design/facet_normal_and_scale_unit.sv @@
// Facet normal and scale unit.
// req_* carries one facet per item: stored normal (Q1.14) and three vertices
// (Q16.16). rsp_* returns the scaled, saturated vertices and the normal.
// csr_* writes the Q8.8 gain; csr_ready is always high. Write it only while
// no item is in flight.
// If the stored normal components sum to zero, a unit normal is rebuilt from
// the negated scaled-edge cross product (zero if null); otherwise it passes through.
// The path from req to rsp_tvalid has 59 register stages, the first loaded
// at the accepting edge: 2 for scaling, 9 for the cross product and
// reduction, 31 for the square root (one result bit per stage), 16 for the
// three dividers (a numerator stage, then one quotient bit per stage) and one
// output register. One item is accepted every cycle while rsp is not stalled.
// Reset clears all valid bits and loads the gain with 1.0.
// When the receiver stalls, the whole pipeline holds and req_tready drops
// in the same cycle; nothing is dropped or repeated.
module facet_normal_and_scale_unit import fns_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // in_normal_x, in_normal_y, in_normal_z, in_a_x..z, in_b_x..z, in_c_x..z
   input  logic [335:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_normal_x, out_normal_y, out_normal_z, out_a_x..z, out_b_x..z, out_c_x..z
   output logic [335:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

   logic [15:0]          scale_ff;
   logic [LAT_TOTAL-1:0] vld_ff;
   logic                 en;
   nrm_type              nrm_in;
   vert_type             vert_in;
   logic                 pass_in;
   vert_type             vert_sc;
   vert_type             vert_d;
   mag_type              m_c;
   logic [2:0]           neg_c;
   logic [SUM_W-1:0]     sum_c;
   logic [LEN_W-1:0]     len_s;
   mag_type              m_d;
   logic [2:0]           neg_d;
   logic                 zero_d;
   nrm_type              nrm_d;
   logic                 pass_d;
   logic [QUOT_W-1:0]    quot [3];
   nrm_type              nrm_out;
   nrm_type              rsp_nrm_ff;
   vert_type             rsp_vert_ff;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_comb begin
      logic signed [17:0] s;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         nrm_in[i] = req_tdata[NORM_W*i +: NORM_W];
         s = s + 18'($signed(nrm_in[i]));
      end
      for (int i = 0; i < 9; i++) begin
         vert_in[i] = req_tdata[3*NORM_W + COORD_W*i +: COORD_W];
      end
      pass_in = (s != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         vld_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            scale_ff <= csr_data;
         end
         if (en) begin
            vld_ff <= {vld_ff[LAT_TOTAL-2:0], req_tvalid};
         end
      end
   end

   fns_scale u_scale (
      .clock (clock), .en (en), .scale (scale_ff), .vin (vert_in), .vout (vert_sc)
   );

   fns_cross u_cross (
      .clock (clock), .en (en), .v (vert_sc), .m (m_c), .neg (neg_c), .sum (sum_c)
   );

   fns_sqrt u_sqrt (
      .clock (clock), .en (en), .v (sum_c), .root (len_s)
   );

   fns_delay #(.W($bits(nrm_type) + 1), .D(LAT_TOTAL - 1)) u_dly_nrm (
      .clock (clock), .en (en), .din ({pass_in, nrm_in}), .dout ({pass_d, nrm_d})
   );

   fns_delay #(.W($bits(vert_type)), .D(LAT_TOTAL - 1 - LAT_SCALE)) u_dly_vert (
      .clock (clock), .en (en), .din (vert_sc), .dout (vert_d)
   );

   fns_delay #(.W($bits(mag_type)), .D(LAT_SQRT)) u_dly_mag (
      .clock (clock), .en (en), .din (m_c), .dout (m_d)
   );

   fns_delay #(.W(4), .D(LAT_SQRT + LAT_DIV)) u_dly_flag (
      .clock (clock), .en (en), .din ({sum_c == '0, neg_c}), .dout ({zero_d, neg_d})
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      fns_div u_div (
         .clock (clock), .en (en), .m (m_d[i]), .len (len_s), .quot (quot[i])
      );
   end

   always_comb begin
      logic [QUOT_W-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = (quot[i] > NORM_ONE) ? NORM_ONE : quot[i];
         if (pass_d) begin
            nrm_out[i] = nrm_d[i];
         end else if (zero_d) begin
            nrm_out[i] = '0;
         end else if (neg_d[i]) begin
            nrm_out[i] = NORM_W'(q);
         end else begin
            nrm_out[i] = NORM_W'(-NORM_W'(q));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_nrm_ff  <= nrm_out;
         rsp_vert_ff <= vert_d;
      end
   end

   assign rsp_tvalid = vld_ff[LAT_TOTAL-1];
   assign rsp_tdata  = {rsp_vert_ff, rsp_nrm_ff};

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set after reset");

   a_quot_cap: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAT_TOTAL-2] && !pass_d && !zero_d) |->
      (quot[0] <= NORM_ONE && quot[1] <= NORM_ONE && quot[2] <= NORM_ONE))
      else $error("normal quotient above one");

   a_zero_normal: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[LAT_TOTAL-2] && zero_d && !pass_d) |=> (rsp_nrm_ff == '0))
      else $error("degenerate facet gave nonzero normal");

   a_pass_normal: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[LAT_TOTAL-2] && pass_d) |=> (rsp_nrm_ff == $past(nrm_d)))
      else $error("stored normal not passed through");
`endif

endmodule
